// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL. Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside of reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== sv/bfp_pkg.sv =====
package bfp_pkg;

  // Default sizes.
  localparam int unsigned MaxNodesDef = 32;
  localparam int unsigned MaxEdgesDef = 1024;

  // Field widths of the stream beats.
  localparam int unsigned NodeFieldW = 6;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned EdgeW      = 2 * NodeFieldW + WeightW;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutIdxW    = 5;
  localparam int unsigned OutDistW   = 32;
  localparam int unsigned OutDataW   = 40;
  localparam int unsigned OutUserW   = 2;

  // Configuration register.
  localparam int unsigned CfgW = 6;
  localparam logic [CfgW-1:0] NumNodesRst = 6'd32;

  // Bit positions inside the result tuser.
  localparam int unsigned UserReachBit = 0;
  localparam int unsigned UserNegBit   = 1;

endpackage

// ===== sv/bellman_ford_potentials.sv =====
// Shortest distances from a source node over a loaded list of weighted edges.
// Edges arrive on the slave stream, one per beat; tlast marks the final edge,
// after which the block stops taking beats and computes. Node num_nodes is the
// source, nodes 0 to num_nodes-1 are reported. Edges naming a node above
// num_nodes are kept but skipped; beats beyond MAX_EDGES stored edges are
// dropped, though their tlast still starts the run.
// Loading takes one cycle per edge. The run is an init step, then num_nodes
// full passes and one check pass over all E stored edges, each edge going in
// turn through the single edge memory read, the distance memory read and the
// shared add/compare unit. The check pass stops at the first edge that still
// improves. Results then follow node by node while the receiver takes them,
// each read from the distance memory into the output register: num_nodes
// beats, the last one marked, or one beat flagging a reachable negative cycle.
// A stalled receiver simply holds the current result beat; the block waits.
// The configuration channel is always ready and must only be written while
// the block is idle. Reset empties the edge list and sets num_nodes to 32.
module bellman_ford_potentials import bfp_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned MAX_EDGES = MaxEdgesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,      // num_nodes
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // edge_source, edge_target, edge_weight
  input  logic                s_axis_tlast_i,  // last_edge
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // node_index, distance
  output logic [OutUserW-1:0] m_axis_tuser_o,  // reachable, negative_cycle
  output logic                m_axis_tlast_o   // last_result
);

  `include "assert_macros.svh"

  localparam int unsigned NW    = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW   = $clog2(MAX_EDGES);
  localparam int unsigned CntW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned DistW = NW + EAW + WeightW + 1;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_EDGE     = 4'd2;
  localparam logic [3:0] S_NODE     = 4'd3;
  localparam logic [3:0] S_RELAX    = 4'd4;
  localparam logic [3:0] S_OUT_RD   = 4'd5;
  localparam logic [3:0] S_OUT_LD   = 4'd6;
  localparam logic [3:0] S_OUT_WAIT = 4'd7;
  localparam logic [3:0] S_NEG      = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CfgW-1:0]  cfg_q;
  logic [CntW-1:0]  edge_cnt_q, edge_cnt_d;
  logic [EAW-1:0]   idx_q, idx_d;
  logic [NW-1:0]    pass_q, pass_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    k_q, k_d;
  logic [MAX_NODES:0] reached_q, reached_d;

  logic                m_valid_q, m_valid_d;
  logic                m_load;
  logic [OutIdxW-1:0]  m_idx_q, m_idx_d;
  logic [OutDistW-1:0] m_dist_q, m_dist_d;
  logic                m_reach_q, m_reach_d;
  logic                m_neg_q, m_neg_d;
  logic                m_last_q, m_last_d;

  logic [NW-1:0] n_eff;

  // Edge memory.
  logic             edge_we, edge_re;
  logic [EAW-1:0]   edge_waddr;
  logic [EdgeW-1:0] edge_rdata;

  // Distance memories, two copies so that source and target read together.
  logic                    dist_we, dist_re;
  logic [NW-1:0]           dist_waddr, dist_raddr_a;
  logic signed [DistW-1:0] dist_wdata, dist_a, dist_b;

  logic [NodeFieldW-1:0]     e_src, e_dst;
  logic signed [WeightW-1:0] e_w;
  logic [NW-1:0]             e_src_n, e_dst_n;
  logic                      in_range, src_ok, dst_reached;
  logic                      improve;
  logic signed [DistW-1:0]   cand;
  logic                      last_e;

  always_comb begin
    n_eff = NW'(cfg_q);
    if (cfg_q == '0) begin
      n_eff = NW'(1);
    end else if (cfg_q > CfgW'(MAX_NODES)) begin
      n_eff = NW'(MAX_NODES);
    end
  end

  assign e_src   = edge_rdata[NodeFieldW-1:0];
  assign e_dst   = edge_rdata[2*NodeFieldW-1:NodeFieldW];
  assign e_w     = edge_rdata[EdgeW-1:2*NodeFieldW];
  assign e_src_n = e_src[NW-1:0];
  assign e_dst_n = e_dst[NW-1:0];

  assign in_range    = (e_src <= NodeFieldW'(n_q)) && (e_dst <= NodeFieldW'(n_q));
  assign src_ok      = in_range && reached_q[e_src_n];
  assign dst_reached = in_range && reached_q[e_dst_n];
  assign last_e      = (CntW'(idx_q) + CntW'(1)) == edge_cnt_q;

  bfp_ram #(
    .WIDTH(EdgeW),
    .DEPTH(MAX_EDGES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(s_axis_tdata_i[EdgeW-1:0]),
    .re_i   (edge_re),
    .raddr_i(idx_q),
    .rdata_o(edge_rdata)
  );

  bfp_ram #(
    .WIDTH(DistW),
    .DEPTH(MAX_NODES + 1)
  ) u_dist_ram_a (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .re_i   (dist_re),
    .raddr_i(dist_raddr_a),
    .rdata_o(dist_a)
  );

  bfp_ram #(
    .WIDTH(DistW),
    .DEPTH(MAX_NODES + 1)
  ) u_dist_ram_b (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .re_i   (dist_re),
    .raddr_i(e_dst_n),
    .rdata_o(dist_b)
  );

  bfp_relax_unit #(
    .DIST_W(DistW)
  ) u_relax (
    .src_ok_i     (src_ok),
    .dst_reached_i(dst_reached),
    .src_dist_i   (dist_a),
    .dst_dist_i   (dist_b),
    .weight_i     (e_w),
    .improve_o    (improve),
    .cand_o       (cand)
  );

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    state_d      = state_q;
    edge_cnt_d   = edge_cnt_q;
    idx_d        = idx_q;
    pass_d       = pass_q;
    n_d          = n_q;
    k_d          = k_q;
    reached_d    = reached_q;
    edge_we      = 1'b0;
    edge_waddr   = edge_cnt_q[EAW-1:0];
    edge_re      = 1'b0;
    dist_we      = 1'b0;
    dist_waddr   = e_dst_n;
    dist_wdata   = cand;
    dist_re      = 1'b0;
    dist_raddr_a = e_src_n;
    m_valid_d    = m_valid_q;
    m_load       = 1'b0;
    m_idx_d      = OutIdxW'(k_q);
    m_dist_d     = reached_q[k_q] ? OutDistW'(dist_a) : '0;
    m_reach_d    = reached_q[k_q];
    m_neg_d      = 1'b0;
    m_last_d     = (k_q + NW'(1)) == n_q;

    unique case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid_i) begin
          if (edge_cnt_q < CntW'(MAX_EDGES)) begin
            edge_we    = 1'b1;
            edge_cnt_d = edge_cnt_q + CntW'(1);
          end
          if (s_axis_tlast_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        n_d              = n_eff;
        reached_d        = '0;
        reached_d[n_eff] = 1'b1;
        dist_we          = 1'b1;
        dist_waddr       = n_eff;
        dist_wdata       = '0;
        idx_d            = '0;
        pass_d           = '0;
        k_d              = '0;
        state_d          = (edge_cnt_q == '0) ? S_OUT_RD : S_EDGE;
      end
      S_EDGE: begin
        edge_re = 1'b1;
        state_d = S_NODE;
      end
      S_NODE: begin
        dist_re = 1'b1;
        state_d = S_RELAX;
      end
      S_RELAX: begin
        if (pass_q == n_q) begin
          // Check pass: any further improvement means a negative cycle.
          if (improve) begin
            state_d = S_NEG;
          end else if (last_e) begin
            state_d = S_OUT_RD;
          end else begin
            idx_d   = idx_q + EAW'(1);
            state_d = S_EDGE;
          end
        end else begin
          if (improve) begin
            dist_we            = 1'b1;
            reached_d[e_dst_n] = 1'b1;
          end
          if (last_e) begin
            idx_d  = '0;
            pass_d = pass_q + NW'(1);
          end else begin
            idx_d = idx_q + EAW'(1);
          end
          state_d = S_EDGE;
        end
      end
      S_OUT_RD: begin
        dist_re      = 1'b1;
        dist_raddr_a = k_q;
        state_d      = S_OUT_LD;
      end
      S_OUT_LD: begin
        m_valid_d = 1'b1;
        m_load    = 1'b1;
        state_d   = S_OUT_WAIT;
      end
      S_NEG: begin
        m_valid_d = 1'b1;
        m_load    = 1'b1;
        m_idx_d   = '0;
        m_dist_d  = '0;
        m_reach_d = 1'b0;
        m_neg_d   = 1'b1;
        m_last_d  = 1'b1;
        state_d   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (m_axis_tready_i) begin
          m_valid_d = 1'b0;
          if (m_last_q) begin
            edge_cnt_d = '0;
            state_d    = S_LOAD;
          end else begin
            k_d     = k_q + NW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cfg_q      <= NumNodesRst;
      edge_cnt_q <= '0;
      idx_q      <= '0;
      pass_q     <= '0;
      n_q        <= NW'(1);
      k_q        <= '0;
      reached_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      edge_cnt_q <= edge_cnt_d;
      idx_q      <= idx_d;
      pass_q     <= pass_d;
      n_q        <= n_d;
      k_q        <= k_d;
      reached_q  <= reached_d;
      m_valid_q  <= m_valid_d;
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_idx_q   <= m_idx_d;
      m_dist_q  <= m_dist_d;
      m_reach_q <= m_reach_d;
      m_neg_q   <= m_neg_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - OutDistW - OutIdxW)'(0), m_dist_q, m_idx_q};
  assign m_axis_tlast_o  = m_last_q;
  always_comb begin
    m_axis_tuser_o               = '0;
    m_axis_tuser_o[UserReachBit] = m_reach_q;
    m_axis_tuser_o[UserNegBit]   = m_neg_q;
  end

  `ASSERT_AT(a_no_load_while_output, m_valid_q |-> !s_axis_tready_o)
  `ASSERT_AT(a_edge_cnt_bound, edge_cnt_q <= CntW'(MAX_EDGES))
  `ASSERT_AT(a_neg_cycle_is_last, (m_valid_q && m_neg_q) |-> m_last_q)
  `ASSERT_NEVER(a_dist_write_state, dist_we && !(state_q == S_RELAX || state_q == S_INIT))
  `ASSERT_AT(a_source_reached, (state_q == S_INIT) |=> reached_q[n_q])

endmodule

// ===== sv/bfp_ram.sv =====
module bfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bfp_relax_unit.sv =====
module bfp_relax_unit import bfp_pkg::*; #(
  parameter int unsigned DIST_W = 33
) (
  input  logic                      src_ok_i,
  input  logic                      dst_reached_i,
  input  logic signed [DIST_W-1:0]  src_dist_i,
  input  logic signed [DIST_W-1:0]  dst_dist_i,
  input  logic signed [WeightW-1:0] weight_i,
  output logic                      improve_o,
  output logic signed [DIST_W-1:0]  cand_o
);

  // The one adder and comparator of the block, shared by every edge and pass.
  assign cand_o    = src_dist_i + DIST_W'(weight_i);
  assign improve_o = src_ok_i && (!dst_reached_i || (cand_o < dst_dist_i));

endmodule
